// ===== src/fmpm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fmpm_pkg;

    // Default sizes of the datapath.
    localparam int PHASE_WIDTH     = 32;
    localparam int TABLE_ADDR_BITS = 10;
    localparam int SAMPLE_WIDTH    = 16;

    // Fixed field and register widths.
    localparam int INC_WIDTH     = 32;
    localparam int CARRIER_WIDTH = 32;
    localparam int AMP_WIDTH     = 16;
    localparam int AMP_FRAC_BITS = 15;
    localparam int APB_DATA_W    = 32;
    localparam int APB_ADDR_W    = 3;

    localparam logic signed [AMP_WIDTH-1:0]     AMP_RESET     = 16'sh7FFF;
    localparam logic        [CARRIER_WIDTH-1:0] CARRIER_RESET = '0;

    // Register select, taken from the word address bit of paddr.
    typedef enum logic {
        REG_CARRIER_STEP = 1'b0,
        REG_AMPLITUDE    = 1'b1
    } t_reg_idx;

    // Load enables of the stages behind the accumulator.
    typedef struct packed {
        logic rom_load;
        logic prod_load;
        logic out_load;
    } t_pipe_en;

    // Constants of the Q30 table generator.
    localparam longint unsigned Q30_ONE     = 64'd1 << 30;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned SINE_DIVISORS [7] = '{
        64'd210, 64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6
    };

    // One quarter-wave entry: sine at the centre of bin k, evaluated with a
    // Horner-form Taylor series in Q30 and scaled to the sample full scale.
    function automatic longint unsigned sine_entry(
        input int unsigned k,
        input int unsigned addr_bits,
        input int unsigned sample_width
    );
        longint unsigned x;
        longint unsigned x2;
        longint unsigned acc;
        longint unsigned s;
        longint unsigned sine_max;
        x   = (HALF_PI_Q30 * (64'(k) * 64'd2 + 64'd1)) >> (addr_bits + 1);
        x2  = (x * x) >> 30;
        acc = Q30_ONE;
        for (int j = 0; j < 7; j++) begin
            acc = Q30_ONE - ((x2 * acc) >> 30) / SINE_DIVISORS[j];
        end
        s        = (x * acc) >> 30;
        sine_max = (64'd1 << (sample_width - 1)) - 64'd1;
        return (s * sine_max + (Q30_ONE >> 1)) >> 30;
    endfunction

endpackage

`default_nettype wire

// ===== src/fm_phase_modulator_top.sv =====
// A sample appears on o_valid once its transaction has passed through every stage in order.
// Throughput: one transaction per cycle while o_stall is low; a held output can stall the input.
// The four stages (accumulator, sine table read, gain multiply, output) close up bubbles.
// Reset clears the phase accumulator, all stage valid flags, carrier_step to zero and
// amplitude to 32767; the sine table is a constant and needs no clearing.
`timescale 1ns / 1ps
`default_nettype none

module fm_phase_modulator_top #(
    parameter int PHASE_WIDTH     = fmpm_pkg::PHASE_WIDTH,
    parameter int TABLE_ADDR_BITS = fmpm_pkg::TABLE_ADDR_BITS,
    parameter int SAMPLE_WIDTH    = fmpm_pkg::SAMPLE_WIDTH
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_valid,
    output logic                                        o_stall,
    input  wire logic signed [fmpm_pkg::INC_WIDTH-1:0]  i_phase_increment,
    output logic                                        o_valid,
    input  wire logic                                   i_stall,
    output logic signed      [SAMPLE_WIDTH-1:0]         o_sample,
    input  wire logic                                   psel,
    input  wire logic                                   penable,
    input  wire logic                                   pwrite,
    input  wire logic        [fmpm_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic        [fmpm_pkg::APB_DATA_W-1:0] pwdata,
    output logic             [fmpm_pkg::APB_DATA_W-1:0] prdata,
    output logic                                        pready
);

    logic [fmpm_pkg::CARRIER_WIDTH-1:0]    w_carrier_step;
    logic signed [fmpm_pkg::AMP_WIDTH-1:0] w_amplitude;
    logic [PHASE_WIDTH-1:0]                w_phase;
    logic [SAMPLE_WIDTH-1:0]               w_magnitude;
    logic                                  w_negate;
    logic                                  w_accept;
    logic                                  w_free1;
    logic                                  w_free2;
    logic                                  w_free3;
    fmpm_pkg::t_pipe_en                    w_en;

    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic r_v4;

    // Stage advance: each stage moves on when the one after it is empty or moving.
    always_comb begin
        w_en.out_load  = r_v3 && (!r_v4 || !i_stall);
        w_free3        = !r_v3 || w_en.out_load;
        w_en.prod_load = r_v2 && w_free3;
        w_free2        = !r_v2 || w_en.prod_load;
        w_en.rom_load  = r_v1 && w_free2;
        w_free1        = !r_v1 || w_en.rom_load;
    end

    assign w_accept = i_valid && w_free1;
    assign o_stall  = !w_free1;

    // Stage valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_accept) begin
                r_v1 <= 1'b1;
            end else if (w_en.rom_load) begin
                r_v1 <= 1'b0;
            end
            if (w_en.rom_load) begin
                r_v2 <= 1'b1;
            end else if (w_en.prod_load) begin
                r_v2 <= 1'b0;
            end
            if (w_en.prod_load) begin
                r_v3 <= 1'b1;
            end else if (w_en.out_load) begin
                r_v3 <= 1'b0;
            end
            if (w_en.out_load) begin
                r_v4 <= 1'b1;
            end else if (!i_stall) begin
                r_v4 <= 1'b0;
            end
        end
    end

    assign o_valid = r_v4;

    fmpm_cfg u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_carrier_step (w_carrier_step),
        .o_amplitude    (w_amplitude)
    );

    fmpm_phase_acc #(
        .PHASE_WIDTH (PHASE_WIDTH)
    ) u_phase_acc (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (w_accept),
        .i_carrier_step    (w_carrier_step),
        .i_phase_increment (i_phase_increment),
        .o_phase           (w_phase)
    );

    fmpm_sine_rom #(
        .PHASE_WIDTH     (PHASE_WIDTH),
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
        .SAMPLE_WIDTH    (SAMPLE_WIDTH)
    ) u_sine_rom (
        .i_clk       (i_clk),
        .i_en        (w_en),
        .i_phase     (w_phase),
        .o_magnitude (w_magnitude),
        .o_negate    (w_negate)
    );

    fmpm_scale #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_scale (
        .i_clk       (i_clk),
        .i_en        (w_en),
        .i_magnitude (w_magnitude),
        .i_negate    (w_negate),
        .i_amplitude (w_amplitude),
        .o_sample    (o_sample)
    );

    // The input is held off only when every stage holds a sample.
    a_stall_only_when_full: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v1 && r_v2 && r_v3 && r_v4)
    ) else $error("input held off while the pipeline has a free stage");

    // The phase only moves when a transaction is accepted.
    a_phase_moves_on_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> $stable(w_phase)
    ) else $error("phase accumulator changed without an accepted transaction");

    // A finished product reaches the output whenever the output is free.
    a_output_fills: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && (!r_v4 || !i_stall)) |=> r_v4
    ) else $error("finished sample not moved into the output register");

endmodule

`default_nettype wire

// ===== src/fmpm_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fmpm_cfg (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_rst_n,
    input  wire logic                                       psel,
    input  wire logic                                       penable,
    input  wire logic                                       pwrite,
    input  wire logic [fmpm_pkg::APB_ADDR_W-1:0]            paddr,
    input  wire logic [fmpm_pkg::APB_DATA_W-1:0]            pwdata,
    output logic      [fmpm_pkg::APB_DATA_W-1:0]            prdata,
    output logic                                            pready,
    output logic      [fmpm_pkg::CARRIER_WIDTH-1:0]         o_carrier_step,
    output logic signed [fmpm_pkg::AMP_WIDTH-1:0]           o_amplitude
);

    logic [fmpm_pkg::CARRIER_WIDTH-1:0]  r_carrier_step;
    logic signed [fmpm_pkg::AMP_WIDTH-1:0] r_amplitude;
    fmpm_pkg::t_reg_idx                  w_sel;
    logic                                w_wr;

    assign pready = 1'b1;
    assign w_sel  = fmpm_pkg::t_reg_idx'(paddr[2]);
    assign w_wr   = psel && penable && pwrite;

    // Register writes complete in the access phase of a transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carrier_step <= fmpm_pkg::CARRIER_RESET;
            r_amplitude    <= fmpm_pkg::AMP_RESET;
        end else if (w_wr) begin
            unique case (w_sel)
                fmpm_pkg::REG_CARRIER_STEP: begin
                    r_carrier_step <= pwdata[fmpm_pkg::CARRIER_WIDTH-1:0];
                end
                fmpm_pkg::REG_AMPLITUDE: begin
                    r_amplitude <= pwdata[fmpm_pkg::AMP_WIDTH-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Read-back of the selected register.
    always_comb begin
        unique case (w_sel)
            fmpm_pkg::REG_CARRIER_STEP: prdata = fmpm_pkg::APB_DATA_W'(r_carrier_step);
            fmpm_pkg::REG_AMPLITUDE:    prdata = fmpm_pkg::APB_DATA_W'($unsigned(r_amplitude));
            default:                    prdata = '0;
        endcase
    end

    assign o_carrier_step = r_carrier_step;
    assign o_amplitude    = r_amplitude;

endmodule

`default_nettype wire

// ===== src/fmpm_phase_acc.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fmpm_phase_acc #(
    parameter int PHASE_WIDTH = fmpm_pkg::PHASE_WIDTH
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire logic                                      i_accept,
    input  wire logic        [fmpm_pkg::CARRIER_WIDTH-1:0] i_carrier_step,
    input  wire logic signed [fmpm_pkg::INC_WIDTH-1:0]     i_phase_increment,
    output logic             [PHASE_WIDTH-1:0]             o_phase
);

    // The sum is formed at least as wide as the input fields, then wraps.
    localparam int SUM_W = (PHASE_WIDTH > fmpm_pkg::INC_WIDTH) ? PHASE_WIDTH
                                                               : fmpm_pkg::INC_WIDTH;

    logic [PHASE_WIDTH-1:0] r_acc;
    logic [PHASE_WIDTH-1:0] n_acc;
    logic [SUM_W-1:0]       w_sum;

    assign w_sum = SUM_W'(r_acc) + SUM_W'(i_carrier_step) + SUM_W'(i_phase_increment);
    assign n_acc = w_sum[PHASE_WIDTH-1:0];

    // The accumulator moves once for every accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_accept) begin
            r_acc <= n_acc;
        end
    end

    assign o_phase = r_acc;

endmodule

`default_nettype wire

// ===== src/fmpm_sine_rom.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fmpm_sine_rom #(
    parameter int PHASE_WIDTH     = fmpm_pkg::PHASE_WIDTH,
    parameter int TABLE_ADDR_BITS = fmpm_pkg::TABLE_ADDR_BITS,
    parameter int SAMPLE_WIDTH    = fmpm_pkg::SAMPLE_WIDTH
) (
    input  wire logic                      i_clk,
    input  wire fmpm_pkg::t_pipe_en        i_en,
    input  wire logic [PHASE_WIDTH-1:0]    i_phase,
    output logic      [SAMPLE_WIDTH-1:0]   o_magnitude,
    output logic                           o_negate
);

    localparam int DEPTH = 2 ** TABLE_ADDR_BITS;

    typedef logic [SAMPLE_WIDTH-1:0] t_rom [DEPTH];

    function automatic t_rom build_rom();
        t_rom rom;
        for (int k = 0; k < DEPTH; k++) begin
            rom[k] = SAMPLE_WIDTH'(fmpm_pkg::sine_entry(k, TABLE_ADDR_BITS, SAMPLE_WIDTH));
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

    logic [1:0]                   w_quad;
    logic [TABLE_ADDR_BITS-1:0]   w_idx;
    logic [TABLE_ADDR_BITS-1:0]   w_addr;
    logic [SAMPLE_WIDTH-1:0]      r_rom_q;
    logic                         r_negate;

    // Odd quadrants run the quarter wave backwards.
    assign w_quad = i_phase[PHASE_WIDTH-1 -: 2];
    assign w_idx  = i_phase[PHASE_WIDTH-3 -: TABLE_ADDR_BITS];
    assign w_addr = w_quad[0] ? ~w_idx : w_idx;

    // Synchronous table read; the lower half-turn sign travels alongside.
    always_ff @(posedge i_clk) begin
        if (i_en.rom_load) begin
            r_rom_q  <= SINE_ROM[w_addr];
            r_negate <= w_quad[1];
        end
    end

    assign o_magnitude = r_rom_q;
    assign o_negate    = r_negate;

endmodule

`default_nettype wire

// ===== src/fmpm_scale.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fmpm_scale #(
    parameter int SAMPLE_WIDTH = fmpm_pkg::SAMPLE_WIDTH
) (
    input  wire logic                                   i_clk,
    input  wire fmpm_pkg::t_pipe_en                     i_en,
    input  wire logic        [SAMPLE_WIDTH-1:0]         i_magnitude,
    input  wire logic                                   i_negate,
    input  wire logic signed [fmpm_pkg::AMP_WIDTH-1:0]  i_amplitude,
    output logic signed      [SAMPLE_WIDTH-1:0]         o_sample
);

    localparam int PROD_W = SAMPLE_WIDTH + fmpm_pkg::AMP_WIDTH;

    logic signed [SAMPLE_WIDTH-1:0] w_sine;
    logic signed [PROD_W-1:0]       r_prod;
    logic signed [SAMPLE_WIDTH-1:0] r_sample;

    // The table magnitude never reaches full scale, so its negation fits.
    assign w_sine = i_negate ? -$signed(i_magnitude) : $signed(i_magnitude);

    // Gain multiply.
    always_ff @(posedge i_clk) begin
        if (i_en.prod_load) begin
            r_prod <= PROD_W'(w_sine) * PROD_W'(i_amplitude);
        end
    end

    // Arithmetic shift by the Q1.15 fraction, which rounds towards minus infinity.
    always_ff @(posedge i_clk) begin
        if (i_en.out_load) begin
            r_sample <= r_prod[fmpm_pkg::AMP_FRAC_BITS +: SAMPLE_WIDTH];
        end
    end

    assign o_sample = r_sample;

endmodule

`default_nettype wire
